FILE: hdl/oamc_pkg.sv
// ----------------------------------------------------------------------------
// oamc_pkg
// Types and constants shared by the obstacle avoidance mode controller.
// ----------------------------------------------------------------------------
package oamc_pkg;

    localparam int DIST_W  = 8;
    localparam int SPEED_W = 8;
    localparam int CMD_W   = 9;
    localparam int DELTA_W = 10;
    localparam int BTIME_W = 12;

    localparam logic [1:0] OP_STEP   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    localparam logic [1:0] TDIR_NONE  = 2'd0;
    localparam logic [1:0] TDIR_LEFT  = 2'd1;
    localparam logic [1:0] TDIR_RIGHT = 2'd2;

    localparam logic [1:0] SWEEP_RIGHT = 2'd0;
    localparam logic [1:0] SWEEP_LEFT  = 2'd2;

    localparam logic [1:0] MODE_CODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_CODE_TURN  = 2'd1;
    localparam logic [1:0] MODE_CODE_BACK  = 2'd2;
    localparam logic [1:0] MODE_CODE_UTURN = 2'd3;

    localparam logic [2:0] REG_DIST_EMERGENCY = 3'd0;
    localparam logic [2:0] REG_DIST_SLOW      = 3'd1;
    localparam logic [2:0] REG_DIST_SAFE      = 3'd2;
    localparam logic [2:0] REG_SPEED_NORMAL   = 3'd3;
    localparam logic [2:0] REG_SPEED_SLOW     = 3'd4;
    localparam logic [2:0] REG_SPEED_TURN     = 3'd5;
    localparam logic [2:0] REG_BACK_TIME      = 3'd6;

    localparam logic [DIST_W-1:0] DIST_MAX       = 8'd200;
    localparam logic [7:0]        SERVO_CENTER   = 8'd90;
    localparam logic [8:0]        TURN_BIAS      = 9'd10;
    localparam logic [8:0]        STEER_MARGIN   = 9'd20;
    localparam logic [7:0]        STEER_OFFSET   = 8'd20;

    localparam logic [7:0] SWEEP_ANGLE_TAB [0:3] = '{8'd30, 8'd90, 8'd150, 8'd90};

    typedef enum logic [3:0] {
        MODE_FWD   = 4'b0001,
        MODE_TURN  = 4'b0010,
        MODE_BACK  = 4'b0100,
        MODE_UTURN = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_emergency;
        logic [DIST_W-1:0]  dist_slow;
        logic [DIST_W-1:0]  dist_safe;
        logic [SPEED_W-1:0] speed_normal;
        logic [SPEED_W-1:0] speed_slow;
        logic [SPEED_W-1:0] speed_turn;
        logic [BTIME_W-1:0] back_time_ms;
    } oamc_cfg_t;

    typedef struct packed {
        logic              active;
        mode_t             mode;
        logic [1:0]        sweep_idx;
        logic [DIST_W-1:0] left_dist;
        logic [DIST_W-1:0] center_dist;
        logic [DIST_W-1:0] right_dist;
        logic [1:0]        turn_dir;
        logic              turn_left;
    } oamc_state_t;

    typedef struct packed {
        logic              is_active;
        logic [1:0]        mode;
        logic [7:0]        servo_angle;
        logic signed [CMD_W-1:0] right_speed;
        logic signed [CMD_W-1:0] left_speed;
    } oamc_res_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        case (m)
            MODE_FWD:   code = MODE_CODE_FWD;
            MODE_TURN:  code = MODE_CODE_TURN;
            MODE_BACK:  code = MODE_CODE_BACK;
            MODE_UTURN: code = MODE_CODE_UTURN;
            default:    code = MODE_CODE_FWD;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/oamc_step.sv
// ----------------------------------------------------------------------------
// oamc_step
// Next-state and drive command logic for one control item.
// ----------------------------------------------------------------------------
module oamc_step import oamc_pkg::*; #(
    parameter int TIMER_BITS = 12
) (
    input  oamc_cfg_t               cfg,
    input  oamc_state_t             st,
    input  logic [TIMER_BITS-1:0]   timer,
    input  logic [1:0]              opcode,
    input  logic [DELTA_W-1:0]      delta_ms,
    input  logic [DIST_W-1:0]       distance_cm,
    output oamc_state_t             st_next,
    output logic [TIMER_BITS-1:0]   timer_next,
    output oamc_res_t               res
);

    localparam logic [TIMER_BITS-1:0] T_TURN_MIN  = TIMER_BITS'(400);
    localparam logic [TIMER_BITS-1:0] T_TURN_MAX  = TIMER_BITS'(1800);
    localparam logic [TIMER_BITS-1:0] T_UTURN_MIN = TIMER_BITS'(600);
    localparam logic [TIMER_BITS-1:0] T_UTURN_MAX = TIMER_BITS'(3000);

    oamc_state_t             w;
    logic [TIMER_BITS-1:0]   t_base;
    logic [TIMER_BITS:0]     t_sum;
    logic [TIMER_BITS-1:0]   el;
    logic                    dt_blocked;
    logic [8:0]              sl;
    logic [8:0]              sr;
    mode_t                   dt_mode;
    logic [1:0]              dt_dir;
    logic                    dt_left;
    logic [SPEED_W-1:0]      slow_red;
    logic signed [CMD_W-1:0] cmd_l;
    logic signed [CMD_W-1:0] cmd_r;
    logic signed [CMD_W-1:0] turn_pos;
    logic signed [CMD_W-1:0] turn_neg;
    logic signed [CMD_W-1:0] slow_pos;
    logic [1:0]              uturn_dir;

    always_comb begin
        w          = st;
        t_base     = timer;
        st_next    = st;
        timer_next = timer;
        cmd_l      = '0;
        cmd_r      = '0;
        t_sum      = '0;
        el         = '0;
        dt_blocked = 1'b0;
        sl         = '0;
        sr         = '0;
        dt_mode    = MODE_TURN;
        dt_dir     = TDIR_NONE;
        dt_left    = 1'b0;
        slow_red   = '0;
        uturn_dir  = TDIR_NONE;
        turn_pos   = $signed({1'b0, cfg.speed_turn});
        turn_neg   = -$signed({1'b0, cfg.speed_turn});
        slow_pos   = $signed({1'b0, cfg.speed_slow});

        if (opcode == OP_STOP) begin
            if (st.active) begin
                st_next.active   = 1'b0;
                st_next.mode     = MODE_FWD;
                st_next.turn_dir = TDIR_NONE;
            end
        end else begin
            if (!st.active) begin
                w.active      = 1'b1;
                w.mode        = MODE_FWD;
                w.sweep_idx   = '0;
                w.left_dist   = DIST_MAX;
                w.center_dist = DIST_MAX;
                w.right_dist  = DIST_MAX;
                w.turn_dir    = TDIR_NONE;
                w.turn_left   = 1'b0;
                t_base        = '0;
            end
            t_sum = {1'b0, t_base} + {{(TIMER_BITS + 1 - DELTA_W){1'b0}}, delta_ms};
            el    = t_sum[TIMER_BITS] ? '1 : t_sum[TIMER_BITS-1:0];

            if (opcode == OP_SAMPLE) begin
                if (w.sweep_idx == SWEEP_RIGHT) begin
                    w.right_dist = distance_cm;
                end else if (w.sweep_idx == SWEEP_LEFT) begin
                    w.left_dist = distance_cm;
                end else begin
                    w.center_dist = distance_cm;
                end
                w.sweep_idx = w.sweep_idx + 2'd1;
            end

            // Turn decision with a bias toward the previous turn direction.
            dt_blocked = (w.left_dist < cfg.dist_slow) && (w.center_dist < cfg.dist_emergency)
                && (w.right_dist < cfg.dist_slow);
            sl = {1'b0, w.left_dist} + ((w.turn_dir == TDIR_LEFT) ? TURN_BIAS : 9'd0);
            sr = {1'b0, w.right_dist} + ((w.turn_dir == TDIR_RIGHT) ? TURN_BIAS : 9'd0);
            if (dt_blocked) begin
                dt_mode = MODE_BACK;
                dt_dir  = TDIR_NONE;
                dt_left = w.turn_left;
            end else if (sl >= sr) begin
                dt_mode = MODE_TURN;
                dt_dir  = TDIR_LEFT;
                dt_left = 1'b1;
            end else begin
                dt_mode = MODE_TURN;
                dt_dir  = TDIR_RIGHT;
                dt_left = 1'b0;
            end

            slow_red = (cfg.speed_slow >= STEER_OFFSET) ? cfg.speed_slow - STEER_OFFSET : '0;

            st_next    = w;
            timer_next = el;

            case (w.mode)
                MODE_FWD: begin
                    if ((w.center_dist < cfg.dist_emergency)
                            || (w.center_dist < cfg.dist_slow)) begin
                        st_next.mode      = dt_mode;
                        st_next.turn_dir  = dt_dir;
                        st_next.turn_left = dt_left;
                        timer_next        = '0;
                    end else if (w.center_dist < cfg.dist_safe) begin
                        if ({1'b0, w.left_dist} > {1'b0, w.right_dist} + STEER_MARGIN) begin
                            cmd_l = $signed({1'b0, slow_red});
                            cmd_r = slow_pos;
                        end else if ({1'b0, w.right_dist} > {1'b0, w.left_dist} + STEER_MARGIN) begin
                            cmd_l = slow_pos;
                            cmd_r = $signed({1'b0, slow_red});
                        end else begin
                            cmd_l = slow_pos;
                            cmd_r = slow_pos;
                        end
                    end else begin
                        cmd_l = $signed({1'b0, cfg.speed_normal});
                        cmd_r = $signed({1'b0, cfg.speed_normal});
                    end
                end
                MODE_TURN: begin
                    if (el < T_TURN_MIN) begin
                        cmd_l = w.turn_left ? turn_neg : turn_pos;
                        cmd_r = w.turn_left ? turn_pos : turn_neg;
                    end else if (w.center_dist > cfg.dist_safe) begin
                        st_next.mode = MODE_FWD;
                        timer_next   = '0;
                    end else if (el > T_TURN_MAX) begin
                        st_next.mode      = dt_mode;
                        st_next.turn_dir  = dt_dir;
                        st_next.turn_left = dt_left;
                        timer_next        = '0;
                    end else begin
                        cmd_l = w.turn_left ? turn_neg : turn_pos;
                        cmd_r = w.turn_left ? turn_pos : turn_neg;
                    end
                end
                MODE_BACK: begin
                    if (el < TIMER_BITS'(cfg.back_time_ms)) begin
                        cmd_l = -slow_pos;
                        cmd_r = -slow_pos;
                    end else begin
                        uturn_dir         = (w.left_dist >= w.right_dist) ? TDIR_LEFT : TDIR_RIGHT;
                        st_next.turn_dir  = uturn_dir;
                        st_next.turn_left = (uturn_dir == TDIR_LEFT);
                        st_next.mode      = MODE_UTURN;
                        timer_next        = '0;
                    end
                end
                MODE_UTURN: begin
                    if ((el > T_UTURN_MIN) && (w.center_dist > cfg.dist_safe)) begin
                        st_next.mode = MODE_FWD;
                        timer_next   = '0;
                    end else if (el > T_UTURN_MAX) begin
                        st_next.mode = MODE_BACK;
                        timer_next   = '0;
                    end else begin
                        cmd_l = (w.turn_dir == TDIR_LEFT) ? turn_neg : turn_pos;
                        cmd_r = (w.turn_dir == TDIR_LEFT) ? turn_pos : turn_neg;
                    end
                end
                default: begin
                    st_next    = w;
                    timer_next = el;
                end
            endcase
        end

        res.left_speed  = cmd_l;
        res.right_speed = cmd_r;
        res.servo_angle = (opcode == OP_STOP) ? SERVO_CENTER : SWEEP_ANGLE_TAB[st_next.sweep_idx];
        res.mode        = mode_code(st_next.mode);
        res.is_active   = st_next.active;
    end

endmodule

FILE: hdl/obstacle_avoid_mode_controller_top.sv
// An item accepted on the input channel is held in the input register, its result is registered
// in the output register, and it is then taken from the result channel.
// Throughput: one item per cycle while the result channel does not stall; the mode state is
// updated in the same cycle the result is registered, so each item sees the prior item's state.
// Reset: synchronous, active low; controller inactive, mode forward, timer and sweep at zero,
// distances at 200 cm, registers at their defaults, both channels empty.
// ----------------------------------------------------------------------------
// obstacle_avoid_mode_controller_top
// Obstacle avoidance mode controller with stream channels and an APB register port.
// ----------------------------------------------------------------------------
module obstacle_avoid_mode_controller_top import oamc_pkg::*; #(
    parameter int TIMER_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // delta_ms[9:0], distance_cm[17:10], zero[23:18]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_speed[8:0], right_speed[17:9], servo_angle[25:18],
                                   // mode[27:26], is_active[28], zero[31:29]
);

    oamc_cfg_t             cfg_reg;
    oamc_state_t           st_reg;
    oamc_state_t           st_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;

    logic                  in_valid_reg;
    logic [1:0]            in_op_reg;
    logic [DELTA_W-1:0]    in_delta_reg;
    logic [DIST_W-1:0]     in_dist_reg;

    logic                  out_valid_reg;
    oamc_res_t             out_res_reg;
    oamc_res_t             res;

    logic                  advance;
    logic                  cfg_wr;
    logic [2:0]            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_emergency <= 8'd15;
            cfg_reg.dist_slow      <= 8'd25;
            cfg_reg.dist_safe      <= 8'd40;
            cfg_reg.speed_normal   <= 8'd200;
            cfg_reg.speed_slow     <= 8'd120;
            cfg_reg.speed_turn     <= 8'd150;
            cfg_reg.back_time_ms   <= 12'd500;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DIST_EMERGENCY: cfg_reg.dist_emergency <= pwdata[7:0];
                REG_DIST_SLOW:      cfg_reg.dist_slow      <= pwdata[7:0];
                REG_DIST_SAFE:      cfg_reg.dist_safe      <= pwdata[7:0];
                REG_SPEED_NORMAL:   cfg_reg.speed_normal   <= pwdata[7:0];
                REG_SPEED_SLOW:     cfg_reg.speed_slow     <= pwdata[7:0];
                REG_SPEED_TURN:     cfg_reg.speed_turn     <= pwdata[7:0];
                REG_BACK_TIME:      cfg_reg.back_time_ms   <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DIST_EMERGENCY: prdata = {24'd0, cfg_reg.dist_emergency};
            REG_DIST_SLOW:      prdata = {24'd0, cfg_reg.dist_slow};
            REG_DIST_SAFE:      prdata = {24'd0, cfg_reg.dist_safe};
            REG_SPEED_NORMAL:   prdata = {24'd0, cfg_reg.speed_normal};
            REG_SPEED_SLOW:     prdata = {24'd0, cfg_reg.speed_slow};
            REG_SPEED_TURN:     prdata = {24'd0, cfg_reg.speed_turn};
            REG_BACK_TIME:      prdata = {20'd0, cfg_reg.back_time_ms};
            default:            prdata = '0;
        endcase
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_delta_reg <= s_tdata[9:0];
            in_dist_reg  <= s_tdata[17:10];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.active      <= 1'b0;
            st_reg.mode        <= MODE_FWD;
            st_reg.sweep_idx   <= '0;
            st_reg.left_dist   <= DIST_MAX;
            st_reg.center_dist <= DIST_MAX;
            st_reg.right_dist  <= DIST_MAX;
            st_reg.turn_dir    <= TDIR_NONE;
            st_reg.turn_left   <= 1'b0;
            timer_reg          <= '0;
        end else if (advance) begin
            st_reg    <= st_next;
            timer_reg <= timer_next;
        end
    end

    oamc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg         (cfg_reg),
        .st          (st_reg),
        .timer       (timer_reg),
        .opcode      (in_op_reg),
        .delta_ms    (in_delta_reg),
        .distance_cm (in_dist_reg),
        .st_next     (st_next),
        .timer_next  (timer_next),
        .res         (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.is_active, out_res_reg.mode, out_res_reg.servo_angle,
                       out_res_reg.right_speed, out_res_reg.left_speed};

endmodule
